@@ sv/rbd_pkg.sv @@
// shared constants, types and the reciprocal table of the box downscaler
package rbd_pkg;

  // limits of the block
  localparam int unsigned MAX_OUT_WIDTH = 1024;
  localparam int unsigned MAX_SCALE     = 16;

  // field and register widths
  localparam int unsigned PIX_W   = 24;
  localparam int unsigned CH_W    = 8;
  localparam int unsigned NUM_CH  = 3;
  localparam int unsigned SCALE_W = 5;
  localparam int unsigned WIDTH_W = 11;
  localparam int unsigned CFG_W   = 11;

  // counter and sum widths
  localparam int unsigned COL_W  = $clog2(MAX_OUT_WIDTH);
  localparam int unsigned SUB_W  = $clog2(MAX_SCALE);
  localparam int unsigned HSUM_W = CH_W + SUB_W;
  localparam int unsigned CSUM_W = 16;
  localparam int unsigned SUM_W  = CSUM_W + 1;
  localparam int unsigned RAM_W  = NUM_CH * CSUM_W;

  // reciprocal divider widths
  localparam int unsigned RECIP_SHIFT = 17;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned PROD_W      = SUM_W + RECIP_W;
  localparam int unsigned AREA_W      = 9;
  localparam int unsigned QUOT_W      = SUM_W;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = QPTR_W + 1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

  // one block sum on its way to the divider
  typedef struct packed {
    logic [NUM_CH-1:0][SUM_W-1:0] sum;
    logic                         row_end;
    logic [SCALE_W-1:0]           scale;
  } rbd_item_t;

  // queue status seen by the top level
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
    logic              empty;
  } rbd_queue_stat_t;

  // floor(2^17 / (s*s)) for block edge s
  function automatic logic [RECIP_W-1:0] recip_of(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] m;
    case (s)
      5'd1:    m = 18'd131072;
      5'd2:    m = 18'd32768;
      5'd3:    m = 18'd14563;
      5'd4:    m = 18'd8192;
      5'd5:    m = 18'd5242;
      5'd6:    m = 18'd3640;
      5'd7:    m = 18'd2674;
      5'd8:    m = 18'd2048;
      5'd9:    m = 18'd1618;
      5'd10:   m = 18'd1310;
      5'd11:   m = 18'd1083;
      5'd12:   m = 18'd910;
      5'd13:   m = 18'd775;
      5'd14:   m = 18'd668;
      5'd15:   m = 18'd582;
      5'd16:   m = 18'd512;
      default: m = 18'd0;
    endcase
    return m;
  endfunction

endpackage

@@ sv/rbd_ram.sv @@
// generic single-write, single-read ram with registered read data
module rbd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/rbd_front.sv @@
// front end: pixel counters, horizontal sums and column sum line store
module rbd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rbd_pkg::SCALE_W-1:0] scale_i,
  input  logic [rbd_pkg::WIDTH_W-1:0] width_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rbd_pkg::PIX_W-1:0]   src_pixel_i,
  output logic                        push_valid_o,
  output rbd_pkg::rbd_item_t          push_item_o,
  input  logic                        queue_full_i,
  output logic                        busy_o
);
  import rbd_pkg::*;

  // position counters and running row sums
  logic [SUB_W-1:0]                sub_q, sub_d;
  logic [COL_W-1:0]                col_q, col_d;
  logic [SUB_W-1:0]                band_q, band_d;
  logic [NUM_CH-1:0][HSUM_W-1:0]   hs_q, hs_d, hs_new;

  // second stage: line store read-modify-write
  logic                            b_valid_q, b_valid_d;
  logic [NUM_CH-1:0][HSUM_W-1:0]   b_hs_q, b_hs_d;
  logic [COL_W-1:0]                b_col_q, b_col_d;
  logic                            b_first_q, b_first_d;
  logic                            b_emit_q, b_emit_d;
  logic                            b_row_end_q, b_row_end_d;
  logic [SCALE_W-1:0]              b_scale_q, b_scale_d;
  logic                            b_fwd_q, b_fwd_d;
  logic [RAM_W-1:0]                b_fwd_data_q, b_fwd_data_d;

  logic                            accept, blk_done, last_band, last_col, b_adv;
  logic                            ram_re, ram_we;
  logic [RAM_W-1:0]                ram_rdata, ram_wdata, base;
  logic [NUM_CH-1:0][SUM_W-1:0]    sum;

  // second stage moves unless its result waits on a full queue
  assign b_adv      = !b_valid_q || !b_emit_q || !queue_full_i;
  assign in_ready_o = b_adv;
  assign accept     = in_valid_i && in_ready_o;

  // block, band and row position
  assign blk_done  = (SCALE_W'(sub_q) + SCALE_W'(1)) >= scale_i;
  assign last_band = (SCALE_W'(band_q) + SCALE_W'(1)) >= scale_i;
  assign last_col  = (WIDTH_W'(col_q) + WIDTH_W'(1)) >= width_i;

  // add the incoming pixel to the row sums
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      hs_new[c] = hs_q[c] + HSUM_W'(src_pixel_i[c*CH_W +: CH_W]);
    end
  end

  // counter update on each accepted beat
  always_comb begin
    sub_d  = sub_q;
    col_d  = col_q;
    band_d = band_q;
    hs_d   = hs_q;
    if (accept) begin
      if (!blk_done) begin
        hs_d  = hs_new;
        sub_d = sub_q + SUB_W'(1);
      end else begin
        hs_d  = '0;
        sub_d = '0;
        if (last_col) begin
          col_d  = '0;
          band_d = last_band ? '0 : band_q + SUB_W'(1);
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q  <= '0;
      col_q  <= '0;
      band_q <= '0;
      hs_q   <= '0;
    end else begin
      sub_q  <= sub_d;
      col_q  <= col_d;
      band_q <= band_d;
      hs_q   <= hs_d;
    end
  end

  // column sum store
  assign ram_re = accept && blk_done;
  assign ram_we = b_valid_q && b_adv;

  rbd_ram #(
    .WIDTH(RAM_W),
    .DEPTH(MAX_OUT_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(b_col_q),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // second stage: add to the stored column sum or start it anew
  assign base = b_fwd_q ? b_fwd_data_q : ram_rdata;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (b_first_q) begin
        sum[c] = SUM_W'(b_hs_q[c]);
      end else begin
        sum[c] = SUM_W'(base[c*CSUM_W +: CSUM_W]) + SUM_W'(b_hs_q[c]);
      end
      ram_wdata[c*CSUM_W +: CSUM_W] = sum[c][CSUM_W-1:0];
    end
  end

  // stage register load; bypass when the read hits the column being written
  always_comb begin
    b_valid_d    = b_valid_q;
    b_hs_d       = b_hs_q;
    b_col_d      = b_col_q;
    b_first_d    = b_first_q;
    b_emit_d     = b_emit_q;
    b_row_end_d  = b_row_end_q;
    b_scale_d    = b_scale_q;
    b_fwd_d      = b_fwd_q;
    b_fwd_data_d = b_fwd_data_q;
    if (b_adv) begin
      b_valid_d = ram_re;
      if (ram_re) begin
        b_hs_d       = hs_new;
        b_col_d      = col_q;
        b_first_d    = (band_q == '0);
        b_emit_d     = last_band;
        b_row_end_d  = last_col;
        b_scale_d    = scale_i;
        b_fwd_d      = b_valid_q && (b_col_q == col_q);
        b_fwd_data_d = ram_wdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_hs_q       <= b_hs_d;
    b_col_q      <= b_col_d;
    b_first_q    <= b_first_d;
    b_emit_q     <= b_emit_d;
    b_row_end_q  <= b_row_end_d;
    b_scale_q    <= b_scale_d;
    b_fwd_q      <= b_fwd_d;
    b_fwd_data_q <= b_fwd_data_d;
  end

  // finished block sums go to the queue
  assign push_valid_o         = b_valid_q && b_emit_q;
  assign push_item_o.sum      = sum;
  assign push_item_o.row_end  = b_row_end_q;
  assign push_item_o.scale    = b_scale_q;

  // a block still in the second stage
  assign busy_o = b_valid_q;

endmodule

@@ sv/rbd_queue.sv @@
// short queue of block sums between front and back
module rbd_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_valid_i,
  input  rbd_pkg::rbd_item_t      push_item_i,
  output logic                    pop_valid_o,
  input  logic                    pop_ready_i,
  output rbd_pkg::rbd_item_t      pop_item_o,
  output rbd_pkg::rbd_queue_stat_t stat_o
);
  import rbd_pkg::*;

  rbd_item_t         entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              full, empty, push, pop;

  assign full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count_q == '0);
  assign push  = push_valid_i && !full;
  assign pop   = pop_ready_i && !empty;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + QCNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign pop_valid_o  = !empty;
  assign pop_item_o   = entries_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

endmodule

@@ sv/rbd_back.sv @@
// back end: divide block sums by the block area with a reciprocal pipeline
module rbd_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      item_valid_i,
  output logic                      item_ready_o,
  input  rbd_pkg::rbd_item_t        item_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rbd_pkg::PIX_W-1:0] avg_pixel_o,
  output logic                      row_end_o,
  output logic                      busy_o
);
  import rbd_pkg::*;

  logic                          adv;
  logic [2*SCALE_W-1:0]          sq;
  logic [RECIP_W-1:0]            recip;

  // stage 1: sum times reciprocal
  logic                          v1_q;
  logic [NUM_CH-1:0][PROD_W-1:0] s1_prod_q;
  logic [NUM_CH-1:0][SUM_W-1:0]  s1_sum_q;
  logic [AREA_W-1:0]             s1_area_q;
  logic                          s1_row_end_q;

  // stage 2: estimate times area
  logic                          v2_q;
  logic [NUM_CH-1:0][QUOT_W-1:0] s2_q0_q;
  logic [NUM_CH-1:0][SUM_W-1:0]  s2_qa_q;
  logic [NUM_CH-1:0][SUM_W-1:0]  s2_sum_q;
  logic [AREA_W-1:0]             s2_area_q;
  logic                          s2_row_end_q;

  // stage 3: corrected quotient in the output register
  logic                          v3_q;
  logic [PIX_W-1:0]              avg_q, avg_d;
  logic                          row_end_q;

  logic [NUM_CH-1:0][QUOT_W-1:0] q0;
  logic [NUM_CH-1:0][SUM_W-1:0]  rem;
  logic [NUM_CH-1:0][QUOT_W-1:0] quot;

  // whole pipeline moves when the output register is free or being taken
  assign adv          = !v3_q || out_ready_i;
  assign item_ready_o = adv;

  assign sq    = item_i.scale * item_i.scale;
  assign recip = recip_of(item_i.scale);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= item_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1 multiply
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s1_prod_q[c] <= PROD_W'(item_i.sum[c]) * PROD_W'(recip);
        s1_sum_q[c]  <= item_i.sum[c];
      end
      s1_area_q    <= sq[AREA_W-1:0];
      s1_row_end_q <= item_i.row_end;
    end
  end

  // stage 2: quotient estimate, at most one below the true value
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      q0[c] = s1_prod_q[c][RECIP_SHIFT +: QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NUM_CH; c++) begin
        s2_q0_q[c]  <= q0[c];
        s2_qa_q[c]  <= SUM_W'(q0[c] * QUOT_W'(s1_area_q));
        s2_sum_q[c] <= s1_sum_q[c];
      end
      s2_area_q    <= s1_area_q;
      s2_row_end_q <= s1_row_end_q;
    end
  end

  // stage 3: one correction step, keep the low byte per channel
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      rem[c]  = s2_sum_q[c] - s2_qa_q[c];
      quot[c] = (rem[c] >= SUM_W'(s2_area_q)) ? s2_q0_q[c] + QUOT_W'(1) : s2_q0_q[c];
      avg_d[c*CH_W +: CH_W] = quot[c][CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      avg_q     <= avg_d;
      row_end_q <= s2_row_end_q;
    end
  end

  assign out_valid_o = v3_q;
  assign avg_pixel_o = avg_q;
  assign row_end_o   = row_end_q;

  // any stage still holding a block
  assign busy_o = v1_q || v2_q || v3_q;

endmodule

@@ sv/rgb_box_downscaler.sv @@
// top level of the rgb888 box-filter downscaler
//
// Source pixels enter on the in_valid_i / in_ready_o channel in raster
// order, one beat per pixel, rows of out_width * scale_factor pixels.
// Each scale_factor by scale_factor block produces one averaged pixel on
// the out_valid_o / out_ready_i channel; row_end_o marks the last output
// of an output row. Config writes (index 0 scale_factor, 1 out_width) use
// cfg_valid_i / cfg_ready_o and are taken only while the block is idle
// and no source beat is offered.
// Throughput: one source pixel per cycle while the queue has room. The
// front end reads and writes one column sum of the line store per
// completed block, which keeps pace with the pixel rate. The beat that
// completes a block sends its sum through the line store read-modify-write,
// the queue, then the three-stage reciprocal divider ending in the output
// register.
// When the receiver stalls, the divider holds, the four-entry queue fills,
// and only then in_ready_o drops. Reset clears counters and queue and
// sets scale_factor to 1 and out_width to 1024; the line store needs no
// clearing since each band overwrites its column sums in its first row.
module rgb_box_downscaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rbd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rbd_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rbd_pkg::PIX_W-1:0]     src_pixel_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rbd_pkg::PIX_W-1:0]     avg_pixel_o,
  output logic                          row_end_o
);
  import rbd_pkg::*;

  logic [SCALE_W-1:0] scale_factor_q, scale_factor_d;
  logic [WIDTH_W-1:0] out_width_q, out_width_d;
  logic [SCALE_W-1:0] eff_scale;
  logic [WIDTH_W-1:0] eff_width;

  logic               push_valid;
  rbd_item_t          push_item;
  logic               pop_valid, pop_ready;
  rbd_item_t          pop_item;
  rbd_queue_stat_t    q_stat;
  logic               front_busy, back_busy;

  // config registers, written only with nothing in flight
  assign cfg_ready_o = !front_busy && q_stat.empty && !back_busy && !in_valid_i;

  always_comb begin
    scale_factor_d = scale_factor_q;
    out_width_d    = out_width_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SCALE: scale_factor_d = cfg_data_i[SCALE_W-1:0];
        REG_WIDTH: out_width_d    = cfg_data_i[WIDTH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_factor_q <= SCALE_W'(1);
      out_width_q    <= WIDTH_W'(MAX_OUT_WIDTH);
    end else begin
      scale_factor_q <= scale_factor_d;
      out_width_q    <= out_width_d;
    end
  end

  // clamp config to the supported range
  always_comb begin
    if (scale_factor_q == '0) begin
      eff_scale = SCALE_W'(1);
    end else if (scale_factor_q > SCALE_W'(MAX_SCALE)) begin
      eff_scale = SCALE_W'(MAX_SCALE);
    end else begin
      eff_scale = scale_factor_q;
    end
    if (out_width_q == '0) begin
      eff_width = WIDTH_W'(1);
    end else if (out_width_q > WIDTH_W'(MAX_OUT_WIDTH)) begin
      eff_width = WIDTH_W'(MAX_OUT_WIDTH);
    end else begin
      eff_width = out_width_q;
    end
  end

  rbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (eff_scale),
    .width_i     (eff_width),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_pixel_i (src_pixel_i),
    .push_valid_o(push_valid),
    .push_item_o (push_item),
    .queue_full_i(q_stat.full),
    .busy_o      (front_busy)
  );

  rbd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_item_i (push_item),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_item_o  (pop_item),
    .stat_o      (q_stat)
  );

  rbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(pop_valid),
    .item_ready_o(pop_ready),
    .item_i      (pop_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .avg_pixel_o (avg_pixel_o),
    .row_end_o   (row_end_o),
    .busy_o      (back_busy)
  );

  // the front end only stalls on a full queue
  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_stat.full)
    else $error("input stalled while queue has room");

  // fill count stays within the queue depth
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  // an item leaving the queue reaches the output while the receiver keeps out_ready_i high
  a_divider_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && pop_ready && out_ready_i) ##1 out_ready_i ##1 out_ready_i
      |=> out_valid_o)
    else $error("divider pipeline lost an item");

endmodule

@@ tb/sv/tb.sv @@
// testbench for the rgb888 box-filter downscaler
`timescale 1ns / 1ps

module tb;
  import rbd_pkg::*;

  localparam int unsigned     CLK_PERIOD   = 8;
  localparam int unsigned     PIPE_LATENCY = 5;
  localparam int unsigned     RANDOM_ITEMS = 2000;
  localparam int unsigned     IDLE_PCT     = 18;
  localparam int unsigned     HOLD_CYCLES  = 200;
  localparam longint unsigned LIMIT_NS     = 4_000_000;

  // one averaged pixel as it should leave the block
  typedef struct packed {
    logic [PIX_W-1:0] avg;
    logic             row_end;
  } avg_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [PIX_W-1:0]     src_pixel_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PIX_W-1:0]     avg_pixel_o;
  logic                 row_end_o;

  // predicted state of the block
  logic [NUM_CH-1:0][CSUM_W-1:0] col_sum_mem [MAX_OUT_WIDTH];
  bit                            col_sum_valid [MAX_OUT_WIDTH];
  logic [NUM_CH-1:0][HSUM_W-1:0] hsum_acc;
  logic [SUB_W-1:0]              sub_col_cnt;
  logic [COL_W-1:0]              out_col_cnt;
  logic [SUB_W-1:0]              band_row_cnt;
  logic [SCALE_W-1:0]            scale_reg;
  logic [WIDTH_W-1:0]            width_reg;

  avg_result_t avg_expected [$];
  avg_result_t head_result;

  bit          src_idle_en  = 1'b1;
  bit          sink_idle_en = 1'b1;
  int unsigned hold_req     = 0;
  int unsigned hold_left    = 0;

  int unsigned err_count       = 0;
  int unsigned pixels_sent     = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned max_scale_used  = 1;
  int unsigned max_width_used  = 1;

  rgb_box_downscaler i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .src_pixel_i (src_pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .avg_pixel_o (avg_pixel_o),
    .row_end_o   (row_end_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #(LIMIT_NS);
    $display("** rgb_box_downscaler: FAILED **");
    $finish;
  end

  // out-of-range register values saturate
  function automatic int unsigned sat_scale(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_SCALE) return MAX_SCALE;
    return v;
  endfunction

  function automatic int unsigned sat_width(input int unsigned v);
    if (v == 0) return 1;
    if (v > MAX_OUT_WIDTH) return MAX_OUT_WIDTH;
    return v;
  endfunction

  // widening a row inside a band must not touch column sums never written
  function automatic bit width_is_safe(input int unsigned new_w);
    int unsigned c;
    if (band_row_cnt == 0) return 1'b1;
    for (c = out_col_cnt; c < new_w; c++)
      if (!col_sum_valid[c]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [PIX_W-1:0] px;
    int               c;
    px = '0;
    case ($urandom_range(7))
      0: px = '0;
      1: px = '1;
      2: for (c = 0; c < NUM_CH; c++) px[c*CH_W +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
      default: px = PIX_W'($urandom);
    endcase
    return px;
  endfunction

  task automatic reset_box_state();
    int c;
    for (c = 0; c < MAX_OUT_WIDTH; c++) begin
      col_sum_mem[c]   = '0;
      col_sum_valid[c] = 1'b0;
    end
    hsum_acc     = '0;
    sub_col_cnt  = '0;
    out_col_cnt  = '0;
    band_row_cnt = '0;
    scale_reg    = 5'd1;
    width_reg    = 11'd1024;
  endtask

  // accumulate one source pixel and queue the average when a block closes
  task automatic advance_box_sums(input logic [PIX_W-1:0] px);
    int unsigned                  s, w, area, c;
    logic [NUM_CH-1:0][SUM_W-1:0] tot;
    avg_result_t                  res;
    bit                           last_band, last_col;
    s = sat_scale(scale_reg);
    w = sat_width(width_reg);
    for (c = 0; c < NUM_CH; c++) hsum_acc[c] = hsum_acc[c] + px[c*CH_W +: CH_W];
    if (sub_col_cnt + 1 < s) begin
      sub_col_cnt = sub_col_cnt + 1'b1;
      return;
    end
    // first row of a band overwrites the column sum
    for (c = 0; c < NUM_CH; c++) begin
      if (band_row_cnt == 0) tot[c] = hsum_acc[c];
      else tot[c] = col_sum_mem[out_col_cnt][c] + hsum_acc[c];
      col_sum_mem[out_col_cnt][c] = tot[c][CSUM_W-1:0];
    end
    col_sum_valid[out_col_cnt] = 1'b1;
    last_band = (band_row_cnt + 1 >= s);
    last_col  = (out_col_cnt + 1 >= w);
    if (last_band) begin
      area = s * s;
      res.avg = '0;
      for (c = 0; c < NUM_CH; c++) res.avg[c*CH_W +: CH_W] = CH_W'(tot[c] / area);
      res.row_end = last_col;
      avg_expected.push_back(res);
    end
    hsum_acc    = '0;
    sub_col_cnt = '0;
    if (last_col) begin
      out_col_cnt  = '0;
      band_row_cnt = last_band ? '0 : band_row_cnt + 1'b1;
    end else begin
      out_col_cnt = out_col_cnt + 1'b1;
    end
  endtask

  // one source beat, with random idle cycles ahead of it
  task automatic send_pixel(input logic [PIX_W-1:0] px);
    @(negedge clk_i);
    while (src_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    src_pixel_i <= px;
    do @(posedge clk_i); while (!in_ready_o);
    pixels_sent++;
    advance_box_sums(px);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SCALE) scale_reg = data[SCALE_W-1:0];
    else width_reg = data[WIDTH_W-1:0];
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every queued average, then for blocks still in flight
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (avg_expected.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // complete the open band so the next beats start a fresh one
  task automatic align_to_band();
    while (sub_col_cnt != 0 || out_col_cnt != 0 || band_row_cnt != 0)
      send_pixel(rand_pixel());
  endtask

  // receiver ready, with random stalls and a requested long hold
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (sink_idle_en && $urandom_range(99) < IDLE_PCT) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_checked++;
      if (avg_expected.size() == 0) begin
        $error("unexpected result beat: avg_pixel %06h row_end %0b", avg_pixel_o, row_end_o);
        err_count++;
      end else begin
        head_result = avg_expected.pop_front();
        if (avg_pixel_o !== head_result.avg) begin
          $error("avg_pixel: expected %06h, actual %06h", head_result.avg, avg_pixel_o);
          err_count++;
        end
        if (row_end_o !== head_result.row_end) begin
          $error("row_end: expected %0b, actual %0b", head_result.row_end, row_end_o);
          err_count++;
        end
      end
    end
  end

  // reset values: scale 1, width 1024, pixels pass unchanged
  task automatic test_default_passthrough();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hA5A5A5);
    send_pixel(24'h5A5A5A);
  endtask

  // zero in both registers acts as one: every pixel ends its row
  task automatic test_clamped_registers();
    drain_pipeline();
    write_reg(REG_SCALE, 11'h7E0);
    write_reg(REG_WIDTH, 11'd0);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);
  endtask

  // 2x2 blocks over stale column sums, with truncating averages
  task automatic test_first_band_row();
    drain_pipeline();
    write_reg(REG_SCALE, 11'd2);
    write_reg(REG_WIDTH, 11'd2);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'h010101);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hFEFEFE);
    send_pixel(24'h000000);
    send_pixel(24'h020202);
  endtask

  // shrink the scale while a block is half done
  task automatic test_midstream_change();
    drain_pipeline();
    write_reg(REG_SCALE, 11'd3);
    write_reg(REG_WIDTH, 11'd2);
    repeat (4) send_pixel(rand_pixel());
    drain_pipeline();
    write_reg(REG_SCALE, 11'd2);
    repeat (6) send_pixel(rand_pixel());
  endtask

  // receiver holds off so the queue fills and the input stalls
  task automatic test_backpressure();
    drain_pipeline();
    write_reg(REG_SCALE, 11'd1);
    write_reg(REG_WIDTH, 11'd5);
    hold_req = HOLD_CYCLES;
    repeat (60) send_pixel(rand_pixel());
  endtask

  // full rate on both sides
  task automatic test_no_idle_burst();
    drain_pipeline();
    write_reg(REG_SCALE, 11'd2);
    write_reg(REG_WIDTH, 11'd8);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    align_to_band();
    repeat (2 * 2 * 2 * 8 * 4) send_pixel(rand_pixel());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // new register values between phases, then whole bands or a stray run
  task automatic random_phase();
    int unsigned      pick, sv, wv, s, w, band_px, k_max, n;
    logic [CFG_W-1:0] data;
    drain_pipeline();
    pick = $urandom_range(3);
    if (pick != 1) begin
      case ($urandom_range(9))
        0:       sv = 0;
        1:       sv = MAX_SCALE;
        2:       sv = $urandom_range(31, MAX_SCALE + 1);
        3:       sv = $urandom_range(MAX_SCALE - 1, 5);
        default: sv = $urandom_range(4, 1);
      endcase
      data = CFG_W'($urandom);
      data[SCALE_W-1:0] = SCALE_W'(sv);
      write_reg(REG_SCALE, data);
    end
    if (pick != 0) begin
      case ($urandom_range(11))
        0:       wv = 0;
        1:       wv = MAX_OUT_WIDTH;
        2:       wv = $urandom_range(2047, MAX_OUT_WIDTH + 1);
        3:       wv = $urandom_range(200, 9);
        default: wv = $urandom_range(8, 1);
      endcase
      if (width_is_safe(sat_width(wv))) write_reg(REG_WIDTH, CFG_W'(wv));
    end
    s = sat_scale(scale_reg);
    w = sat_width(width_reg);
    if (s > max_scale_used) max_scale_used = s;
    if (w > max_width_used) max_width_used = w;
    src_idle_en  = ($urandom_range(9) != 0);
    sink_idle_en = src_idle_en;
    band_px = s * s * w;
    if (band_px <= 1100 && $urandom_range(99) < 80) begin
      align_to_band();
      k_max = 1100 / band_px;
      if (k_max > 3) k_max = 3;
      n = band_px * $urandom_range(k_max, 1);
    end else begin
      n = $urandom_range(40, 1);
    end
    repeat (n) send_pixel(rand_pixel());
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  task automatic test_random_streams();
    int unsigned start;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) random_phase();
  endtask

  // main sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_SCALE;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    src_pixel_i = '0;
    reset_box_state();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_passthrough();
    test_clamped_registers();
    test_first_band_row();
    test_midstream_change();
    test_backpressure();
    test_no_idle_burst();
    test_random_streams();

    drain_pipeline();
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    $display("run covered %0d source pixels, %0d averaged pixels, %0d register writes",
             pixels_sent, results_checked, cfg_writes);
    $display("scale factors up to %0d, rows up to %0d wide, one %0d-cycle receiver hold",
             max_scale_used, max_width_used, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("** rgb_box_downscaler: PASSED **");
    end else begin
      $display("** rgb_box_downscaler: FAILED **");
    end
    $finish;
  end

endmodule
